### rtl/core/hrf_pkg.sv
// shared types and constants of the homopolymer run filter
`default_nettype none
package hrf_pkg;

  localparam int unsigned SYM_W   = 8;
  localparam int unsigned RUN_W   = 8;
  localparam int unsigned ABUND_W = 31;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [ABUND_W-1:0] ABUND_MAX = {ABUND_W{1'b1}};
  localparam logic [POS_W-1:0]   TAG_LEN   = 3'd6;
  localparam logic [RUN_W-1:0]   RUN_MAX   = {RUN_W{1'b1}};

  localparam logic [SYM_W-1:0] CHAR_A    = 8'h41;
  localparam logic [SYM_W-1:0] CHAR_T    = 8'h54;
  localparam logic [SYM_W-1:0] CHAR_C    = 8'h43;
  localparam logic [SYM_W-1:0] CHAR_G    = 8'h47;
  localparam logic [SYM_W-1:0] CHAR_U    = 8'h55;
  localparam logic [SYM_W-1:0] CHAR_SEMI = 8'h3B;
  localparam logic [SYM_W-1:0] CHAR_S    = 8'h73;
  localparam logic [SYM_W-1:0] CHAR_I    = 8'h69;
  localparam logic [SYM_W-1:0] CHAR_Z    = 8'h7A;
  localparam logic [SYM_W-1:0] CHAR_E    = 8'h65;
  localparam logic [SYM_W-1:0] CHAR_EQ   = 8'h3D;
  localparam logic [SYM_W-1:0] CHAR_0    = 8'h30;
  localparam logic [SYM_W-1:0] CHAR_9    = 8'h39;

  localparam logic [RUN_W-1:0]   HOMOP_RESET  = 8'd7;
  localparam logic [ABUND_W-1:0] BYPASS_RESET = '0;

  typedef enum logic {
    REG_RUN_LIMIT  = 1'b0,
    REG_BYPASS_THR = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             in_header;
    logic             last_of_record;
  } item_t;

  typedef struct packed {
    logic [RUN_W-1:0]   run_limit;
    logic [ABUND_W-1:0] bypass_thr;
  } cfg_t;

  typedef struct packed {
    logic               keep;
    logic               run_found;
    logic               size_tag_found;
    logic [ABUND_W-1:0] abundance;
  } result_t;

  function automatic logic [SYM_W-1:0] tag_char(input logic [POS_W-1:0] pos);
    logic [SYM_W-1:0] c;
    unique case (pos)
      3'd0:    c = CHAR_SEMI;
      3'd1:    c = CHAR_S;
      3'd2:    c = CHAR_I;
      3'd3:    c = CHAR_Z;
      3'd4:    c = CHAR_E;
      3'd5:    c = CHAR_EQ;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/hrf_cfg_regs.sv
// apb configuration registers of the homopolymer run filter
`default_nettype none
module hrf_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [hrf_pkg::ADDR_W-1:0] paddr,
  input  wire logic [hrf_pkg::DATA_W-1:0] pwdata,
  output logic      [hrf_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output hrf_pkg::cfg_t                   cfg
);

  hrf_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = hrf_pkg::reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_limit  <= hrf_pkg::HOMOP_RESET;
      cfg.bypass_thr <= hrf_pkg::BYPASS_RESET;
    end else if (wr) begin
      unique case (idx)
        hrf_pkg::REG_RUN_LIMIT:  cfg.run_limit  <= pwdata[hrf_pkg::RUN_W-1:0];
        hrf_pkg::REG_BYPASS_THR: cfg.bypass_thr <= pwdata[hrf_pkg::ABUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hrf_pkg::REG_RUN_LIMIT:
        prdata = {{(hrf_pkg::DATA_W-hrf_pkg::RUN_W){1'b0}}, cfg.run_limit};
      hrf_pkg::REG_BYPASS_THR:
        prdata = {{(hrf_pkg::DATA_W-hrf_pkg::ABUND_W){1'b0}}, cfg.bypass_thr};
      default:
        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/hrf_in_stage.sv
// input register stage of the homopolymer run filter
`default_nettype none
module hrf_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [hrf_pkg::SYM_W-1:0] symbol,
  input  wire logic                      in_header,
  input  wire logic                      last_of_record,
  input  wire logic                      out_free,
  output logic                           go,
  output hrf_pkg::item_t                 item
);

  logic item_valid;
  logic take;

  // only a record end needs room in the output register
  assign go       = item_valid && (!item.last_of_record || out_free);
  assign in_stall = item_valid && !go;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (go) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.symbol         <= symbol;
      item.in_header      <= in_header;
      item.last_of_record <= last_of_record;
    end
  end

endmodule
`default_nettype wire

### rtl/core/hrf_record_core.sv
// per-record state: tag match, abundance parse, run tracking, verdict
`default_nettype none
module hrf_record_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            go,
  input  wire hrf_pkg::item_t  item,
  input  wire hrf_pkg::cfg_t   cfg,
  output logic                 res_valid,
  output hrf_pkg::result_t     res
);

  logic [hrf_pkg::SYM_W-1:0]   previous_symbol, previous_symbol_next;
  logic [hrf_pkg::RUN_W-1:0]   run_length, run_length_next;
  logic                        run_hit, run_hit_next;
  logic [hrf_pkg::POS_W-1:0]   tag_match_position, tag_match_position_next;
  logic                        reading_digits, reading_digits_next;
  logic                        tag_seen, tag_seen_next;
  logic [hrf_pkg::ABUND_W-1:0] size_accumulator, size_accumulator_next;

  logic [hrf_pkg::SYM_W-1:0]   c;
  logic                        is_digit;
  logic                        is_nuc;
  logic [hrf_pkg::ABUND_W+3:0] times_ten;

  assign c        = item.symbol;
  assign is_digit = (c >= hrf_pkg::CHAR_0) && (c <= hrf_pkg::CHAR_9);
  assign is_nuc   = (c == hrf_pkg::CHAR_A) || (c == hrf_pkg::CHAR_T) ||
                    (c == hrf_pkg::CHAR_C) || (c == hrf_pkg::CHAR_G) ||
                    (c == hrf_pkg::CHAR_U);
  assign times_ten = {1'b0, size_accumulator, 3'b000} +
                     {3'b000, size_accumulator, 1'b0} +
                     {{(hrf_pkg::ABUND_W){1'b0}}, c[3:0]};

  always_comb begin
    previous_symbol_next    = previous_symbol;
    run_length_next         = run_length;
    run_hit_next            = run_hit;
    tag_match_position_next = tag_match_position;
    reading_digits_next     = reading_digits;
    tag_seen_next           = tag_seen;
    size_accumulator_next   = size_accumulator;

    if (item.in_header) begin
      if (reading_digits) begin
        if (is_digit) begin
          if (times_ten > {4'b0000, hrf_pkg::ABUND_MAX}) begin
            size_accumulator_next = hrf_pkg::ABUND_MAX;
          end else begin
            size_accumulator_next = times_ten[hrf_pkg::ABUND_W-1:0];
          end
        end else begin
          reading_digits_next = 1'b0;
        end
      end else if (!tag_seen) begin
        if (c == hrf_pkg::tag_char(tag_match_position)) begin
          if (tag_match_position == hrf_pkg::TAG_LEN - 3'd1) begin
            tag_seen_next           = 1'b1;
            reading_digits_next     = 1'b1;
            tag_match_position_next = '0;
          end else begin
            tag_match_position_next = tag_match_position + 3'd1;
          end
        end else begin
          tag_match_position_next = (c == hrf_pkg::CHAR_SEMI) ? 3'd1 : 3'd0;
        end
      end
    end else begin
      if (is_nuc) begin
        if (run_length != '0 && c == previous_symbol) begin
          if (run_length != hrf_pkg::RUN_MAX) begin
            run_length_next = run_length + 8'd1;
          end
        end else begin
          run_length_next = 8'd1;
        end
      end else begin
        run_length_next = '0;
      end
      previous_symbol_next = c;
      if (run_length_next > cfg.run_limit) begin
        run_hit_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (go && item.last_of_record)) begin
      previous_symbol    <= '0;
      run_length         <= '0;
      run_hit            <= 1'b0;
      tag_match_position <= '0;
      reading_digits     <= 1'b0;
      tag_seen           <= 1'b0;
      size_accumulator   <= '0;
    end else if (go) begin
      previous_symbol    <= previous_symbol_next;
      run_length         <= run_length_next;
      run_hit            <= run_hit_next;
      tag_match_position <= tag_match_position_next;
      reading_digits     <= reading_digits_next;
      tag_seen           <= tag_seen_next;
      size_accumulator   <= size_accumulator_next;
    end
  end

  assign res_valid          = go && item.last_of_record;
  assign res.run_found      = run_hit_next;
  assign res.size_tag_found = tag_seen_next;
  assign res.abundance      = size_accumulator_next;
  assign res.keep           = !run_hit_next ||
                              (cfg.bypass_thr != '0 &&
                               size_accumulator_next >= cfg.bypass_thr);

`ifndef SYNTHESIS
  a_digits_need_tag: assert property (@(posedge clk) disable iff (rst)
    reading_digits |-> tag_seen)
    else $error("digit parse active without a matched tag");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    tag_match_position < hrf_pkg::TAG_LEN)
    else $error("tag match position past tag length");

  a_pos_idle_after_tag: assert property (@(posedge clk) disable iff (rst)
    tag_seen |-> tag_match_position == '0)
    else $error("tag matcher still moving after tag seen");

  a_record_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (run_length == '0 && !run_hit && !tag_seen && size_accumulator == '0))
    else $error("record state not cleared after record end");
`endif

endmodule
`default_nettype wire

### rtl/core/homopolymer_run_filter.sv
// top level of the homopolymer run filter
// usage:
//   input channel: one character beat per cycle (symbol, in_header, last_of_record)
//   with in_valid / in_stall; header characters first, then sequence characters.
//   output channel: one result beat per record (keep, run_found, size_tag_found,
//   abundance) with out_valid / out_stall, issued for the beat with last_of_record.
//   apb port: register 0 at 0x0 is the homopolymer threshold, register 1 at 0x4
//   the size bypass threshold; write only while the block is idle.
// path: a record-end beat is taken into the input register, then goes through the
//   per-record logic into the output register, where it waits until out_stall is low.
// throughput: one beat per cycle while no record-end beat waits on a stalled output,
//   as the per-record state updates on every accepted beat.
// reset: rst is synchronous; thresholds return to 7 and 0, all record state
//   clears and both register stages empty.
// stall: while out_stall holds a pending result, non-final beats keep flowing;
//   a record-end beat waits in the input register and in_stall rises.
`default_nettype none
module homopolymer_run_filter (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [hrf_pkg::SYM_W-1:0]  symbol,
  input  wire logic                       in_header,
  input  wire logic                       last_of_record,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            keep,
  output logic                            run_found,
  output logic                            size_tag_found,
  output logic [hrf_pkg::ABUND_W-1:0]     abundance,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [hrf_pkg::ADDR_W-1:0] paddr,
  input  wire logic [hrf_pkg::DATA_W-1:0] pwdata,
  output logic      [hrf_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  hrf_pkg::cfg_t    cfg;
  hrf_pkg::item_t   item;
  hrf_pkg::result_t res;
  logic             go;
  logic             res_valid;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  hrf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hrf_in_stage u_in (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .symbol         (symbol),
    .in_header      (in_header),
    .last_of_record (last_of_record),
    .out_free       (out_free),
    .go             (go),
    .item           (item)
  );

  hrf_record_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .item      (item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      keep           <= res.keep;
      run_found      <= res.run_found;
      size_tag_found <= res.size_tag_found;
      abundance      <= res.abundance;
    end
  end

endmodule
`default_nettype wire

### bench/tb_homopolymer_run_filter.sv
// testbench for the homopolymer run filter: directed and random records against a predictor
module tb_homopolymer_run_filter;
  import hrf_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned NUM_PHASES      = 7;
  localparam int unsigned ITEMS_PER_PHASE = 120;
  localparam int unsigned REPORT_MAX      = 10;
  localparam int unsigned SETTLE_CYCLES   = 6;
  localparam int unsigned IDLE_PCT        = 28;
  localparam int unsigned NUM_DIRECTED    = 21;

  localparam logic [SYM_W-1:0] CASE_BIT = 8'h20;
  localparam logic [0:5][SYM_W-1:0] SIZE_TAG =
    {CHAR_SEMI, CHAR_S, CHAR_I, CHAR_Z, CHAR_E, CHAR_EQ};
  localparam logic [0:4][SYM_W-1:0] BASES = {CHAR_A, CHAR_T, CHAR_C, CHAR_G, CHAR_U};

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             hdr;
  } char_beat_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             hdr;
    logic             last;
    logic             typed;
    result_t          want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [SYM_W-1:0]    symbol;
  logic                in_header;
  logic                last_of_record;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                keep;
  logic                run_found;
  logic                size_tag_found;
  logic [ABUND_W-1:0]  abundance;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  homopolymer_run_filter dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .symbol         (symbol),
    .in_header      (in_header),
    .last_of_record (last_of_record),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .keep           (keep),
    .run_found      (run_found),
    .size_tag_found (size_tag_found),
    .abundance      (abundance),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // filter settings and per-record tracking as the predictor sees them
  logic [RUN_W-1:0]   homop_limit;
  logic [ABUND_W-1:0] bypass_level;
  logic [SYM_W-1:0]   prev_base;
  logic [RUN_W-1:0]   cur_run;
  logic               run_marked;
  logic [POS_W-1:0]   tag_pos;
  logic               parsing_size;
  logic               tag_done;
  logic [ABUND_W-1:0] size_value;

  result_t      expected_verdicts[$];
  char_beat_t   record_beats[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  bit           quiet = 1'b0;

  dir_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    '{CHAR_A, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 31'd0}},
    '{CHAR_G, 1'b0, 1'b0, 1'b0, '0},
    '{CHAR_G, 1'b0, 1'b0, 1'b0, '0},
    '{CHAR_G, 1'b0, 1'b0, 1'b0, '0},
    '{CHAR_G, 1'b0, 1'b0, 1'b0, '0},
    '{CHAR_G, 1'b0, 1'b0, 1'b0, '0},
    '{CHAR_G, 1'b0, 1'b0, 1'b0, '0},
    '{CHAR_G, 1'b0, 1'b0, 1'b0, '0},
    '{CHAR_G, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 31'd0}},
    '{CHAR_SEMI, 1'b1, 1'b0, 1'b0, '0},
    '{CHAR_SEMI, 1'b1, 1'b0, 1'b0, '0},
    '{CHAR_S, 1'b1, 1'b0, 1'b0, '0},
    '{CHAR_I, 1'b1, 1'b0, 1'b0, '0},
    '{CHAR_Z, 1'b1, 1'b0, 1'b0, '0},
    '{CHAR_E, 1'b1, 1'b0, 1'b0, '0},
    '{CHAR_EQ, 1'b1, 1'b0, 1'b0, '0},
    '{CHAR_0 + 8'd4, 1'b1, 1'b0, 1'b0, '0},
    '{CHAR_0 + 8'd2, 1'b1, 1'b0, 1'b0, '0},
    '{CHAR_A | CASE_BIT, 1'b0, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 31'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_base(input logic [SYM_W-1:0] s);
    return s == CHAR_A || s == CHAR_T || s == CHAR_C || s == CHAR_G || s == CHAR_U;
  endfunction

  task automatic add_beat(input logic [SYM_W-1:0] s, input logic hdr);
    char_beat_t b;
    b.sym = s;
    b.hdr = hdr;
    record_beats.insert(record_beats.size(), b);
  endtask

  task automatic add_verdict(input result_t v);
    expected_verdicts.insert(expected_verdicts.size(), v);
  endtask

  task automatic clear_record();
    prev_base    = '0;
    cur_run      = '0;
    run_marked   = 1'b0;
    tag_pos      = '0;
    parsing_size = 1'b0;
    tag_done     = 1'b0;
    size_value   = '0;
  endtask

  task automatic advance_record(input logic [SYM_W-1:0] s, input logic hdr, input logic last,
                                output logic done, output result_t verdict);
    int unsigned digit;
    int unsigned acc;
    done    = 1'b0;
    verdict = '0;
    if (hdr) begin
      if (parsing_size) begin
        if (s >= CHAR_0 && s <= CHAR_9) begin
          digit = s - CHAR_0;
          acc   = size_value;
          if (acc > (ABUND_MAX - digit) / 10) size_value = ABUND_MAX;
          else size_value = ABUND_W'(acc * 10 + digit);
        end else begin
          parsing_size = 1'b0;
        end
      end else if (!tag_done) begin
        if (tag_pos < TAG_LEN && s == SIZE_TAG[tag_pos]) begin
          tag_pos = tag_pos + 1'b1;
          if (tag_pos == TAG_LEN) begin
            tag_done     = 1'b1;
            parsing_size = 1'b1;
            tag_pos      = '0;
          end
        end else begin
          tag_pos = (s == CHAR_SEMI) ? POS_W'(1) : '0;
        end
      end
    end else begin
      if (is_base(s)) begin
        if (cur_run != 0 && s == prev_base) begin
          if (cur_run != RUN_MAX) cur_run = cur_run + 1'b1;
        end else begin
          cur_run = RUN_W'(1);
        end
      end else begin
        cur_run = '0;
      end
      prev_base = s;
      if (cur_run > homop_limit) run_marked = 1'b1;
    end
    if (last) begin
      done                   = 1'b1;
      verdict.keep           = !run_marked || (bypass_level != 0 && size_value >= bypass_level);
      verdict.run_found      = run_marked;
      verdict.size_tag_found = tag_done;
      verdict.abundance      = size_value;
      clear_record();
    end
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_RUN_LIMIT:  homop_limit  = val[RUN_W-1:0];
      REG_BYPASS_THR: bypass_level = val[ABUND_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_beat(input logic [SYM_W-1:0] s, input logic hdr, input logic last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    symbol         <= s;
    in_header      <= hdr;
    last_of_record <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_and_predict(input logic [SYM_W-1:0] s, input logic hdr,
                                  input logic last);
    logic    done;
    result_t verdict;
    send_beat(s, hdr, last);
    advance_record(s, hdr, last, done, verdict);
    if (done) add_verdict(verdict);
  endtask

  task automatic drain_verdicts();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic add_header_noise(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(3) == 0) add_beat(CHAR_SEMI, 1'b1);
      else add_beat(SYM_W'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic add_size_tag();
    int unsigned n;
    for (int i = 0; i < 6; i++) add_beat(SIZE_TAG[i], 1'b1);
    if ($urandom_range(7) == 0) n = $urandom_range(9, 12);
    else n = $urandom_range(0, 3);
    repeat (n) add_beat(SYM_W'(CHAR_0 + $urandom_range(9)), 1'b1);
  endtask

  task automatic build_record(input bit long_runs);
    int unsigned kind;
    int unsigned n;
    int unsigned run_len;
    logic [SYM_W-1:0] base;
    record_beats.delete();
    kind = $urandom_range(9);
    if (kind == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) add_beat(SYM_W'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    if (kind == 1) begin
      add_header_noise($urandom_range(1, 5));
    end else if (kind == 2) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) add_beat(SIZE_TAG[i], 1'b1);
      add_header_noise(1);
      if ($urandom_range(1) == 0) add_size_tag();
    end else begin
      add_header_noise($urandom_range(0, 3));
      add_size_tag();
      if ($urandom_range(3) == 0) begin
        add_beat(CHAR_SEMI, 1'b1);
        add_size_tag();
      end
    end
    n = $urandom_range(0, 4);
    repeat (n) begin
      base = BASES[$urandom_range(4)];
      if (long_runs && $urandom_range(7) == 0) run_len = $urandom_range(250, 260);
      else run_len = $urandom_range(1, homop_limit > 12 ? 14 : homop_limit + 3);
      repeat (run_len) add_beat(base, 1'b0);
      case ($urandom_range(3))
        0: add_beat(SYM_W'($urandom_range(255)), 1'b0);
        1: add_beat(BASES[$urandom_range(4)] | CASE_BIT, 1'b0);
        default: ;
      endcase
    end
    if (record_beats.size() == 0)
      add_beat(SYM_W'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  always @(negedge clk) begin
    out_stall <= !rst && !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{keep, run_found, size_tag_found, abundance};
      if (expected_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected verdict: keep=%0b run=%0b tag=%0b abundance=%0d",
                   got.keep, got.run_found, got.size_tag_found, got.abundance);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.keep !== want.keep || got.run_found !== want.run_found ||
            got.size_tag_found !== want.size_tag_found || got.abundance !== want.abundance) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("verdict mismatch: expected keep=%0b run=%0b tag=%0b abundance=%0d,",
                     want.keep, want.run_found, want.size_tag_found, want.abundance,
                     " got keep=%0b run=%0b tag=%0b abundance=%0d",
                     got.keep, got.run_found, got.size_tag_found, got.abundance);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_homopolymer_run_filter: FAIL");
      $finish;
    end
  end

  initial begin
    logic               done;
    result_t            verdict;
    logic [RUN_W-1:0]   thr;
    logic [ABUND_W-1:0] bypass;
    int unsigned        sent;
    bit                 paused;
    rst            = 1'b1;
    in_valid       = 1'b0;
    symbol         = '0;
    in_header      = 1'b0;
    last_of_record = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    homop_limit    = HOMOP_RESET;
    bypass_level   = BYPASS_RESET;
    clear_record();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed records at the reset thresholds
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_beat(directed_rows[i].sym, directed_rows[i].hdr, directed_rows[i].last);
      advance_record(directed_rows[i].sym, directed_rows[i].hdr, directed_rows[i].last,
                     done, verdict);
      if (done) add_verdict(directed_rows[i].typed ? directed_rows[i].want : verdict);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_verdicts();
      case (p)
        0: begin thr = 8'd2;   bypass = '0;         end
        1: begin thr = 8'd0;   bypass = 31'd3;      end
        2: begin thr = 8'd1;   bypass = 31'd100;    end
        3: begin thr = 8'd254; bypass = 31'd1;      end
        4: begin thr = 8'd255; bypass = ABUND_MAX;  end
        5: begin
          thr    = RUN_W'($urandom_range(2, 20));
          bypass = ABUND_W'($urandom_range(1, 1000));
        end
        default: begin
          thr    = RUN_W'($urandom_range(2, 254));
          bypass = ABUND_W'($urandom());
        end
      endcase
      apb_write(REG_RUN_LIMIT, DATA_W'(thr));
      apb_write(REG_BYPASS_THR, DATA_W'(bypass));
      quiet  = (p == 5);
      sent   = 0;
      paused = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        build_record(p == 3 || p == 4);
        for (int i = 0; i < record_beats.size(); i++)
          send_and_predict(record_beats[i].sym, record_beats[i].hdr,
                           i == record_beats.size() - 1);
        sent += record_beats.size();
        // hold the sender until every pending verdict is out
        if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
          paused = 1'b1;
          drain_verdicts();
        end
      end
    end

    drain_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_homopolymer_run_filter: PASS");
    end else begin
      $display("tb_homopolymer_run_filter: FAIL");
    end
    $finish;
  end

endmodule
